// File: design/frx_pkg.sv
// Package with the phase type, the framing bytes and the register indexes of the receiver.
package frx_pkg;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_SUM,
        PH_SERVICE,
        PH_PAYLOAD,
        PH_EMIT
    } t_phase;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAB;
    localparam logic [7:0] TAIL_LAST  = 8'hFB;

    localparam logic [1:0] CFG_SERVICE_A = 2'd0;
    localparam logic [1:0] CFG_SERVICE_B = 2'd1;
    localparam logic [1:0] CFG_SERVICE_C = 2'd2;

    localparam logic [7:0] SERVICE_A_RESET = 8'd1;
    localparam logic [7:0] SERVICE_B_RESET = 8'd2;
    localparam logic [7:0] SERVICE_C_RESET = 8'd3;

endpackage

// File: design/frx_in_if.sv
// Channel interface that carries received bytes into the receiver.
interface frx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: design/frx_out_if.sv
// Channel interface that carries the results of accepted frames out of the receiver.
interface frx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] service;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output service, output payload_byte, output has_byte,
                    output last, input ready);
    modport sink (input valid, input service, input payload_byte, input has_byte,
                  input last, output ready);
endinterface

// File: design/framed_packet_receiver.sv
// Framed packet receiver: header hunt, service check, payload buffer, checksum and output run.
// Received bytes are accepted while no output run is in progress and the output register is free or being read.
// A passing terminator with no payload gives its single result in the cycle after it is accepted.
// Otherwise an output run follows, in which each result waits for the registered read of the
// payload memory and then for a free output register before it is loaded.
// Reset clears all control state and loads service codes 1, 2 and 3; the payload memory is not cleared.
module framed_packet_receiver
    import frx_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    frx_in_if.sink      i_in,
    frx_out_if.source   o_out
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

    t_phase          r_phase, n_phase;
    logic            r_hdr, n_hdr;
    logic [7:0]      r_length, n_length;
    logic [7:0]      r_sum, n_sum;
    logic [7:0]      r_service, n_service;
    logic [CW-1:0]   r_count, n_count;
    logic [7:0]      r_total, n_total;
    logic [7:0]      r_prev, n_prev;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic            r_rd_ok, n_rd_ok;
    logic [7:0]      r_code_a, r_code_b, r_code_c;

    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_service, n_out_service;
    logic [7:0]      r_out_byte, n_out_byte;
    logic            r_out_has, n_out_has;
    logic            r_out_last, n_out_last;

    logic [7:0]      mem [PAYLOAD_DEPTH];
    logic [7:0]      r_rd_data;
    logic            mem_we;

    logic            in_acc;
    logic            out_free;
    logic            emit_load;
    logic            emit_last;
    logic [7:0]      b;
    logic [CW+7:0]   n_wide;
    logic            check_ok;

    assign b         = i_in.rx_byte;
    assign out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_phase != PH_EMIT) && out_free;
    assign in_acc    = i_in.valid && i_in.ready;
    assign n_wide    = {8'd0, r_count} - (CW + 8)'(1);
    assign check_ok  = (n_wide[7:0] == (r_length - 8'd1))
                    && ((r_total - r_prev) == (r_sum - r_service));
    assign emit_load = (r_phase == PH_EMIT) && r_rd_ok && out_free;
    assign emit_last = ((CW'(r_ptr) + CW'(2)) == r_count);

    assign o_out.valid        = r_out_valid;
    assign o_out.service      = r_out_service;
    assign o_out.payload_byte = r_out_byte;
    assign o_out.has_byte     = r_out_has;
    assign o_out.last         = r_out_last;

    always_comb begin
        n_phase       = r_phase;
        n_hdr         = r_hdr;
        n_length      = r_length;
        n_sum         = r_sum;
        n_service     = r_service;
        n_count       = r_count;
        n_total       = r_total;
        n_prev        = r_prev;
        n_ptr         = r_ptr;
        n_rd_ok       = r_rd_ok;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_service = r_out_service;
        n_out_byte    = r_out_byte;
        n_out_has     = r_out_has;
        n_out_last    = r_out_last;
        mem_we        = 1'b0;

        case (r_phase)
            PH_HUNT: begin
                if (in_acc) begin
                    if (b == (r_hdr ? HDR_SECOND : HDR_FIRST)) begin
                        if (r_hdr) begin
                            n_hdr   = 1'b0;
                            n_phase = PH_LENGTH;
                        end else begin
                            n_hdr = 1'b1;
                        end
                    end else begin
                        n_hdr = 1'b0;
                    end
                end
            end
            PH_LENGTH: begin
                if (in_acc) begin
                    n_length = b;
                    n_phase  = PH_SUM;
                end
            end
            PH_SUM: begin
                if (in_acc) begin
                    n_sum   = b;
                    n_phase = PH_SERVICE;
                end
            end
            PH_SERVICE: begin
                if (in_acc) begin
                    if (b == r_code_a || b == r_code_b || b == r_code_c) begin
                        n_service = b;
                        n_count   = '0;
                        n_total   = 8'd0;
                        n_prev    = 8'd0;
                        n_phase   = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (in_acc) begin
                    if (b != TAIL_LAST) begin
                        if (r_count >= CW'(PAYLOAD_DEPTH)) begin
                            n_phase = PH_HUNT;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            n_total = r_total + b;
                            n_prev  = b;
                        end
                    end else if (r_count == '0 || !check_ok) begin
                        n_phase = PH_HUNT;
                    end else if (r_count == CW'(1)) begin
                        n_out_valid   = 1'b1;
                        n_out_service = r_service;
                        n_out_byte    = 8'd0;
                        n_out_has     = 1'b0;
                        n_out_last    = 1'b1;
                        n_phase       = PH_HUNT;
                    end else begin
                        n_ptr   = '0;
                        n_rd_ok = 1'b0;
                        n_phase = PH_EMIT;
                    end
                end
            end
            PH_EMIT: begin
                if (emit_load) begin
                    n_out_valid   = 1'b1;
                    n_out_service = r_service;
                    n_out_byte    = r_rd_data;
                    n_out_has     = 1'b1;
                    n_out_last    = emit_last;
                    n_rd_ok       = 1'b0;
                    n_ptr         = r_ptr + AW'(1);
                    if (emit_last) begin
                        n_phase = PH_HUNT;
                    end
                end else begin
                    n_rd_ok = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_hdr       <= 1'b0;
            r_length    <= 8'd0;
            r_sum       <= 8'd0;
            r_service   <= 8'd0;
            r_count     <= '0;
            r_total     <= 8'd0;
            r_prev      <= 8'd0;
            r_ptr       <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr       <= n_hdr;
            r_length    <= n_length;
            r_sum       <= n_sum;
            r_service   <= n_service;
            r_count     <= n_count;
            r_total     <= n_total;
            r_prev      <= n_prev;
            r_ptr       <= n_ptr;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_service <= n_out_service;
        r_out_byte    <= n_out_byte;
        r_out_has     <= n_out_has;
        r_out_last    <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_a <= SERVICE_A_RESET;
            r_code_b <= SERVICE_B_RESET;
            r_code_c <= SERVICE_C_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SERVICE_A: r_code_a <= i_cfg_data;
                CFG_SERVICE_B: r_code_b <= i_cfg_data;
                CFG_SERVICE_C: r_code_c <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[AW-1:0]] <= b;
        end
        r_rd_data <= mem[r_ptr];
    end

`ifndef NO_ASSERTIONS
    a_last_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && emit_last) |=> (r_phase == PH_HUNT && r_out_valid && r_out_last))
        else $error("final result of a run did not return the receiver to header hunt");

    a_emit_pointer_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EMIT) |-> ((CW'(r_ptr) + CW'(1)) < r_count))
        else $error("output run pointer beyond the stored payload");

    a_read_waits_for_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EMIT && r_rd_ok && !out_free) |=> (r_rd_ok && $stable(r_ptr)))
        else $error("memory read data lost while the output register was full");
`endif

endmodule

// File: bench/framed_packet_receiver_test.sv
// Self-checking testbench for the framed packet receiver: random framing, stalls and service codes.
`timescale 1ns / 1ps

module framed_packet_receiver_test
    import frx_pkg::*;
();

    localparam int PAYLOAD_DEPTH = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;
    localparam logic [7:0] TAIL_FIRST = 8'hFA;

    typedef struct packed {
        logic [7:0] service;
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       last;
    } t_frame_result;

    class frame_scoreboard;
        logic [7:0]    codes [3];
        t_phase        phase;
        int            hdr_count;
        logic [7:0]    decl_len;
        logic [7:0]    decl_sum;
        logic [7:0]    frame_svc;
        int            stored;
        logic [7:0]    store [PAYLOAD_DEPTH];
        t_frame_result expected_results [$];
        int            mismatches;

        function new();
            codes[0]   = SERVICE_A_RESET;
            codes[1]   = SERVICE_B_RESET;
            codes[2]   = SERVICE_C_RESET;
            phase      = PH_HUNT;
            hdr_count  = 0;
            decl_len   = 8'd0;
            decl_sum   = 8'd0;
            frame_svc  = 8'd0;
            stored     = 0;
            mismatches = 0;
        endfunction

        function void set_code(logic [1:0] idx, logic [7:0] value);
            case (idx)
                CFG_SERVICE_A: codes[0] = value;
                CFG_SERVICE_B: codes[1] = value;
                CFG_SERVICE_C: codes[2] = value;
                default: ;
            endcase
        endfunction

        function void drop_frame();
            phase     = PH_HUNT;
            decl_len  = 8'd0;
            decl_sum  = 8'd0;
            frame_svc = 8'd0;
            stored    = 0;
        endfunction

        function void close_frame();
            int            n;
            logic [7:0]    n8;
            logic [7:0]    total;
            logic [7:0]    want_len;
            logic [7:0]    want_sum;
            t_frame_result r;
            if (stored == 0) begin
                drop_frame();
                return;
            end
            n        = stored - 1;
            n8       = n[7:0];
            want_len = decl_len - 8'd1;
            if (n8 != want_len) begin
                drop_frame();
                return;
            end
            total = 8'd0;
            for (int i = 0; i < n; i++) begin
                total = total + store[i];
            end
            want_sum = decl_sum - frame_svc;
            if (total != want_sum) begin
                drop_frame();
                return;
            end
            if (n == 0) begin
                r.service      = frame_svc;
                r.payload_byte = 8'd0;
                r.has_byte     = 1'b0;
                r.last         = 1'b1;
                expected_results.push_back(r);
            end else begin
                for (int i = 0; i < n; i++) begin
                    r.service      = frame_svc;
                    r.payload_byte = store[i];
                    r.has_byte     = 1'b1;
                    r.last         = (i == n - 1);
                    expected_results.push_back(r);
                end
            end
            drop_frame();
        endfunction

        function void note_rx_byte(logic [7:0] b);
            logic [7:0] wanted;
            case (phase)
                PH_HUNT: begin
                    drop_frame();
                    wanted = (hdr_count == 0) ? HDR_FIRST : HDR_SECOND;
                    if (b == wanted) begin
                        hdr_count++;
                    end else begin
                        hdr_count = 0;
                    end
                    if (hdr_count >= 2) begin
                        hdr_count = 0;
                        phase     = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    decl_len = b;
                    phase    = PH_SUM;
                end
                PH_SUM: begin
                    decl_sum = b;
                    phase    = PH_SERVICE;
                end
                PH_SERVICE: begin
                    if (b == codes[0] || b == codes[1] || b == codes[2]) begin
                        frame_svc = b;
                        phase     = PH_PAYLOAD;
                    end else begin
                        drop_frame();
                    end
                end
                PH_PAYLOAD: begin
                    if (b != TAIL_LAST) begin
                        if (stored >= PAYLOAD_DEPTH) begin
                            drop_frame();
                        end else begin
                            store[stored] = b;
                            stored++;
                        end
                    end else begin
                        close_frame();
                    end
                end
                default: drop_frame();
            endcase
        endfunction

        function void check_result(logic [7:0] service, logic [7:0] payload_byte,
                                   logic has_byte, logic last);
            t_frame_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: svc=%02h byte=%02h has=%0b last=%0b",
                             service, payload_byte, has_byte, last);
                end
                return;
            end
            want = expected_results.pop_front();
            if (service !== want.service || payload_byte !== want.payload_byte ||
                has_byte !== want.has_byte || last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display({"mismatch: expected svc=%02h byte=%02h has=%0b last=%0b,",
                              " got svc=%02h byte=%02h has=%0b last=%0b"},
                             want.service, want.payload_byte, want.has_byte, want.last,
                             service, payload_byte, has_byte, last);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    frx_in_if  rx_chan ();
    frx_out_if res_chan ();

    framed_packet_receiver #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (rx_chan),
        .o_out      (res_chan)
    );

    frame_scoreboard scoreboard;
    logic [7:0]      cur_codes [3];
    logic [7:0]      body_q [$];
    int              send_idle_pct = 34;
    int              recv_idle_pct = 49;
    int              hold_req      = 0;
    int              bytes_sent    = 0;
    int              cycle_count   = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** framed_packet_receiver: FAILED **");
            $finish;
        end
    end

    initial begin
        int hold_seen;
        hold_seen = 0;
        res_chan.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                res_chan.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                res_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_chan.valid === 1'b1 && res_chan.ready === 1'b1) begin
            scoreboard.check_result(res_chan.service, res_chan.payload_byte,
                                    res_chan.has_byte, res_chan.last);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            rx_chan.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.rx_byte <= b;
        do @(posedge i_clk); while (rx_chan.ready !== 1'b1);
        scoreboard.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic settle();
        rx_chan.valid <= 1'b0;
        do @(posedge i_clk); while (scoreboard.expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_codes(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        logic [7:0] values [3];
        values = '{a, b, c};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[1:0];
            i_cfg_data <= values[i];
            @(posedge i_clk);
            scoreboard.set_code(i[1:0], values[i]);
            cur_codes[i] = values[i];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] sum,
                              input logic [7:0] svc, input logic [7:0] tail);
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        push_byte(len);
        push_byte(sum);
        push_byte(svc);
        foreach (body_q[i]) push_byte(body_q[i]);
        push_byte(tail);
        push_byte(TAIL_LAST);
    endtask

    function automatic logic [7:0] non_term_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(255)); while (v == TAIL_LAST);
        return v;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0: return HDR_FIRST;
            1: return HDR_SECOND;
            2: return TAIL_LAST;
            3: return TAIL_FIRST;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void fill_body(int n);
        body_q.delete();
        repeat (n) body_q.push_back(non_term_byte());
    endfunction

    function automatic logic [7:0] body_total();
        logic [7:0] total;
        total = 8'd0;
        foreach (body_q[i]) total = total + body_q[i];
        return total;
    endfunction

    function automatic bit code_known(logic [7:0] v);
        return v == cur_codes[0] || v == cur_codes[1] || v == cur_codes[2];
    endfunction

    task automatic send_random_frame();
        int         kind;
        int         n;
        logic [7:0] svc;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] tail;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 6)) push_byte(noise_byte());
            return;
        end
        n = ($urandom_range(19) == 0) ? PAYLOAD_DEPTH - 1 : $urandom_range(0, 12);
        if (kind < 15) begin
            n = PAYLOAD_DEPTH + $urandom_range(0, 2);
        end
        fill_body(n);
        svc  = cur_codes[2'($urandom_range(2))];
        len  = 8'(n + 1);
        sum  = body_total() + svc;
        tail = $urandom_range(1) ? TAIL_FIRST : non_term_byte();
        if (kind >= 15 && kind < 25) begin
            do svc = 8'($urandom_range(255)); while (code_known(svc));
        end else if (kind >= 25 && kind < 35) begin
            case ($urandom_range(2))
                0: len = 8'h00;
                1: len = 8'hFF;
                default: len = len + 8'($urandom_range(1, 255));
            endcase
        end else if (kind >= 35 && kind < 45) begin
            sum = sum + 8'($urandom_range(1, 255));
        end else if (kind >= 45 && kind < 50) begin
            push_byte(HDR_FIRST);
            push_byte(HDR_SECOND);
            push_byte(len);
            push_byte(sum);
            push_byte(svc);
            repeat ($urandom_range(0, 4)) push_byte(non_term_byte());
            return;
        end
        send_frame(len, sum, svc, tail);
    endtask

    task automatic random_segment(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_random_frame();
    endtask

    initial begin
        scoreboard   = new();
        cur_codes[0] = SERVICE_A_RESET;
        cur_codes[1] = SERVICE_B_RESET;
        cur_codes[2] = SERVICE_C_RESET;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_SERVICE_A;
        i_cfg_data      <= 8'd0;
        rx_chan.valid   <= 1'b0;
        rx_chan.rx_byte <= 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty payload with the second reset code.
        body_q.delete();
        send_frame(8'h01, SERVICE_B_RESET, SERVICE_B_RESET, TAIL_FIRST);
        // A repeated first header byte breaks the header without a re-test.
        push_byte(HDR_FIRST);
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        // Unknown service code.
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'h07);
        // Terminator with nothing stored.
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        push_byte(8'h01);
        push_byte(SERVICE_C_RESET);
        push_byte(SERVICE_C_RESET);
        push_byte(TAIL_LAST);
        // Extreme payload values and a tail byte other than the usual one.
        body_q = '{8'h00, 8'hFF};
        send_frame(8'h03, 8'hFF + SERVICE_C_RESET, SERVICE_C_RESET, 8'h5A);
        settle();

        write_codes(8'h00, 8'hFF, 8'($urandom_range(255)));
        send_idle_pct = 34;
        recv_idle_pct = 49;
        random_segment(70);
        settle();

        write_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        send_idle_pct = 49;
        recv_idle_pct = 34;
        random_segment(35);
        rx_chan.valid <= 1'b0;
        do @(posedge i_clk); while (scoreboard.expected_results.size() != 0);
        random_segment(35);
        settle();

        write_codes(HDR_FIRST, HDR_SECOND, TAIL_LAST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= hold_req + 1;
        repeat (2) begin
            fill_body(PAYLOAD_DEPTH - 1);
            send_frame(8'(PAYLOAD_DEPTH), body_total() + cur_codes[0], cur_codes[0],
                       TAIL_FIRST);
        end
        random_segment(70);
        settle();

        if (scoreboard.mismatches == 0 && scoreboard.expected_results.size() == 0) begin
            $display("** framed_packet_receiver: PASSED **");
        end else begin
            $display("** framed_packet_receiver: FAILED **");
        end
        $finish;
    end

endmodule
